// ===== src/dirty_field_tracking_table_defines.svh =====
// Assertion macros for the dirty field tracking table.
// Used by the top level only.
`ifndef DIRTY_FIELD_TRACKING_TABLE_DEFINES_SVH
`define DIRTY_FIELD_TRACKING_TABLE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DFTT_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define DFTT_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

// ===== src/dftt_pkg.sv =====
// Package for the dirty field tracking table: command and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dftt_pkg;
    localparam logic [2:0] CMD_DIRTY = 3'd0;
    localparam logic [2:0] CMD_QKEY  = 3'd1;
    localparam logic [2:0] CMD_QPOS  = 3'd2;
    localparam logic [2:0] CMD_REM   = 3'd3;
    localparam logic [2:0] CMD_CLR   = 3'd4;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EXTFULL = 2'd3;
    localparam int MASK_BITS = 32;
endpackage
`default_nettype wire

// ===== src/dftt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dftt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/dirty_field_tracking_table.sv =====
// Dirty field tracking table: ordered key table with dirty masks and
// extended field lists. Depends on dftt_pkg, dftt_ram and the defines header.
//
// Usage: one request channel (command, key, field, position) and one result
// channel (status, key, field, valid, last), both valid/ready. A request is
// processed alone; the next is taken once its last result has been taken.
// Entry records (key, mask, ext count) live in one RAM, extended fields in
// a second RAM, both with registered reads. A key search reads the entries
// in order and checks each key. A query then steps through the 32 mask bits,
// one per cycle while the result register is free, then reads out each
// extended field. A remove copies each later entry down, its record and then
// its EXT_DEPTH extended field slots. A dirty command sets the mask bit, or
// scans the extended fields and appends the field if absent and there is
// room. Reset clears the entry count, state and output valid only; no
// clearing pass is needed since entries are fully written on append. Clear
// resets the entry count when it is accepted. When the receiver stalls, the
// result register holds and the sequencer waits; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none
`include "dirty_field_tracking_table_defines.svh"
module dirty_field_tracking_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int EXT_DEPTH   = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_command,
    input  wire logic [31:0] i_object_key,
    input  wire logic [30:0] i_field_number,
    input  wire logic [3:0]  i_table_position,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [31:0]      o_found_key,
    output logic [30:0]      o_dirty_field,
    output logic             o_field_valid,
    output logic             o_last
);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int EW  = $clog2(EXT_DEPTH + 1);
    localparam int XW  = (EXT_DEPTH > 1) ? $clog2(EXT_DEPTH) : 1;
    localparam int FD  = TABLE_DEPTH * EXT_DEPTH;
    localparam int FAW = $clog2(FD);
    localparam int RW  = 64 + EW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_SCHK   = 4'd2;
    localparam logic [3:0] S_DEC    = 4'd3;
    localparam logic [3:0] S_XRD    = 4'd4;
    localparam logic [3:0] S_XCHK   = 4'd5;
    localparam logic [3:0] S_MASK   = 4'd6;
    localparam logic [3:0] S_QXRD   = 4'd7;
    localparam logic [3:0] S_QXOUT  = 4'd8;
    localparam logic [3:0] S_MVRD   = 4'd9;
    localparam logic [3:0] S_MVWR   = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_PRD    = 4'd12;
    localparam logic [3:0] S_PWAIT  = 4'd13;

    logic [3:0]    r_state;
    logic [CW-1:0] r_count;
    logic [2:0]    r_cmd;
    logic [31:0]   r_key;
    logic [30:0]   r_field;
    logic [AW-1:0] r_pos;
    logic [CW-1:0] r_idx;
    logic [EW-1:0] r_xi;
    logic [5:0]    r_bit;
    logic          r_any;
    logic [31:0]   r_mask;
    logic [EW-1:0] r_ecnt;

    logic          r_ov;
    logic [1:0]    r_ost;
    logic [31:0]   r_okey;
    logic [30:0]   r_ofld;
    logic          r_ofv;
    logic          r_olast;

    logic          e_we;
    logic [AW-1:0] e_wa, e_ra;
    logic [RW-1:0] e_wd, e_rd;
    logic          x_we;
    logic [FAW-1:0] x_wa, x_ra;
    logic [30:0]   x_wd, x_rd;

    dftt_ram #(.WIDTH(RW), .DEPTH(TABLE_DEPTH)) u_entry (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd),
        .i_raddr(e_ra), .o_rdata(e_rd));
    dftt_ram #(.WIDTH(31), .DEPTH(FD)) u_ext (
        .i_clk(i_clk), .i_we(x_we), .i_waddr(x_wa), .i_wdata(x_wd),
        .i_raddr(x_ra), .o_rdata(x_rd));

    wire [31:0]   rd_key  = e_rd[RW-1 -: 32];
    wire [31:0]   rd_mask = e_rd[EW +: 32];
    wire [EW-1:0] rd_cnt  = e_rd[EW-1:0];
    wire out_free = !r_ov || i_ready;
    wire [CW-1:0] tpos_w = CW'(i_table_position);

    function automatic logic [FAW-1:0] xaddr(input logic [AW-1:0] p,
                                             input logic [EW-1:0] j);
        logic [FAW:0] a;
        a = (FAW+1)'(p) * (FAW+1)'(EXT_DEPTH) + (FAW+1)'(j);
        return a[FAW-1:0];
    endfunction

    assign o_ready = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_found_key = r_okey;
    assign o_dirty_field = r_ofld;
    assign o_field_valid = r_ofv;
    assign o_last = r_olast;

    logic [3:0]    n_state;
    logic [CW-1:0] n_count;
    logic [2:0]    n_cmd;
    logic [31:0]   n_key;
    logic [30:0]   n_field;
    logic [AW-1:0] n_pos;
    logic [CW-1:0] n_idx;
    logic [EW-1:0] n_xi;
    logic [5:0]    n_bit;
    logic          n_any;
    logic [31:0]   n_mask;
    logic [EW-1:0] n_ecnt;
    logic          n_ov;
    logic [1:0]    n_ost;
    logic [31:0]   n_okey;
    logic [30:0]   n_ofld;
    logic          n_ofv;
    logic          n_olast;

    always_comb begin
        n_state = r_state; n_count = r_count; n_cmd = r_cmd; n_key = r_key;
        n_field = r_field; n_pos = r_pos; n_idx = r_idx; n_xi = r_xi;
        n_bit = r_bit; n_any = r_any; n_mask = r_mask; n_ecnt = r_ecnt;
        n_ov = r_ov && !i_ready; n_ost = r_ost; n_okey = r_okey;
        n_ofld = r_ofld; n_ofv = r_ofv; n_olast = r_olast;
        e_we = 1'b0; e_wa = r_pos; e_wd = {r_key, r_mask, r_ecnt};
        e_ra = r_idx[AW-1:0];
        x_we = 1'b0; x_wa = xaddr(r_pos, r_ecnt); x_wd = r_field;
        x_ra = xaddr(r_pos, r_xi);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd = i_command; n_key = i_object_key;
                    n_field = i_field_number; n_idx = '0;
                    n_okey = 32'd0; n_ofld = 31'd0; n_ofv = 1'b0;
                    n_olast = 1'b1; n_ost = dftt_pkg::ST_INVALID;
                    priority if (i_command == dftt_pkg::CMD_CLR) begin
                        n_count = '0; n_ost = dftt_pkg::ST_OK; n_ov = 1'b1;
                    end else if (i_command == dftt_pkg::CMD_QPOS) begin
                        if (tpos_w >= r_count) n_ov = 1'b1;
                        else begin
                            n_pos = i_table_position[AW-1:0];
                            n_state = S_PRD;
                        end
                    end else if ((i_command == dftt_pkg::CMD_DIRTY ||
                                  i_command == dftt_pkg::CMD_QKEY ||
                                  i_command == dftt_pkg::CMD_REM) &&
                                 i_object_key != 32'd0) begin
                        n_state = S_SRCH;
                    end else begin
                        n_ov = 1'b1;
                    end
                end
            end
            S_PRD: begin
                e_ra = r_pos; n_state = S_PWAIT;
            end
            S_PWAIT: begin
                n_key = rd_key; n_mask = rd_mask; n_ecnt = rd_cnt;
                n_bit = '0; n_xi = '0; n_any = 1'b0; n_state = S_MASK;
            end
            S_SRCH: begin
                if (r_idx >= r_count) n_state = S_DEC;
                else begin
                    e_ra = r_idx[AW-1:0]; n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                if (rd_key == r_key) begin
                    n_pos = r_idx[AW-1:0]; n_mask = rd_mask; n_ecnt = rd_cnt;
                    n_state = S_DEC;
                end else begin
                    n_idx = r_idx + 1'b1; n_state = S_SRCH;
                end
            end
            S_DEC: begin
                // r_idx >= r_count means the key was absent
                if (r_idx >= r_count) begin
                    if (r_cmd != dftt_pkg::CMD_DIRTY || r_count >= CW'(TABLE_DEPTH)) begin
                        n_ost = (r_cmd == dftt_pkg::CMD_DIRTY) ?
                                dftt_pkg::ST_FULL : dftt_pkg::ST_INVALID;
                        n_state = S_OUT;
                    end else begin
                        n_pos = r_count[AW-1:0]; n_mask = '0; n_ecnt = '0;
                        n_count = r_count + 1'b1;
                        n_idx = '0;
                        n_state = S_XRD; n_xi = '0;
                    end
                end else if (r_cmd == dftt_pkg::CMD_QKEY) begin
                    n_bit = '0; n_xi = '0; n_any = 1'b0; n_state = S_MASK;
                end else if (r_cmd == dftt_pkg::CMD_REM) begin
                    n_idx = r_idx + 1'b1; n_state = S_MVRD;
                end else begin
                    n_xi = '0; n_state = S_XRD;
                end
            end
            S_XRD: begin
                if (r_field < 31'(dftt_pkg::MASK_BITS)) begin
                    e_we = 1'b1;
                    e_wd = {r_key, r_mask | (32'd1 << r_field[4:0]), r_ecnt};
                    n_ost = dftt_pkg::ST_OK; n_okey = r_key; n_state = S_OUT;
                end else if (r_xi >= r_ecnt) begin
                    if (r_ecnt >= EW'(EXT_DEPTH)) begin
                        e_we = (r_ecnt == '0);
                        n_ost = dftt_pkg::ST_EXTFULL;
                    end else begin
                        e_we = 1'b1; x_we = 1'b1;
                        e_wd = {r_key, r_mask, r_ecnt + 1'b1};
                        n_ost = dftt_pkg::ST_OK; n_okey = r_key;
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_XCHK;
                end
            end
            S_XCHK: begin
                if (x_rd == r_field) begin
                    n_ost = dftt_pkg::ST_OK; n_okey = r_key; n_state = S_OUT;
                end else begin
                    n_xi = r_xi + 1'b1; n_state = S_XRD;
                end
            end
            S_MASK: begin
                if (out_free) begin
                    if (r_bit == 6'd32) n_state = S_QXRD;
                    else begin
                        n_bit = r_bit + 1'b1;
                        if (r_mask[r_bit[4:0]]) begin
                            n_ov = 1'b1; n_ost = dftt_pkg::ST_OK; n_okey = r_key;
                            n_ofld = 31'(r_bit); n_ofv = 1'b1; n_any = 1'b1;
                            n_olast = (r_ecnt == '0) &&
                                      ((r_mask >> r_bit[4:0]) == 32'd1);
                            if (n_olast) n_state = S_IDLE;
                        end
                    end
                end
            end
            S_QXRD: begin
                if (r_xi >= r_ecnt || r_xi >= EW'(EXT_DEPTH)) begin
                    if (!r_any) begin
                        n_ost = dftt_pkg::ST_OK; n_okey = r_key; n_state = S_OUT;
                    end else n_state = S_IDLE;
                end else n_state = S_QXOUT;
            end
            S_QXOUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_ost = dftt_pkg::ST_OK; n_okey = r_key;
                    n_ofld = x_rd; n_ofv = 1'b1; n_any = 1'b1;
                    n_olast = (r_xi + 1'b1 >= r_ecnt);
                    n_xi = r_xi + 1'b1;
                    n_state = n_olast ? S_IDLE : S_QXRD;
                end
            end
            S_MVRD: begin
                if (r_idx >= r_count) begin
                    n_count = r_count - 1'b1;
                    n_ost = dftt_pkg::ST_OK; n_okey = r_key; n_state = S_OUT;
                end else begin
                    e_ra = r_idx[AW-1:0];
                    n_xi = '0; n_state = S_MVWR;
                end
            end
            S_MVWR: begin
                // r_xi counts the copy step; x_ra reads the source field
                x_ra = xaddr(r_idx[AW-1:0], r_xi);
                if (r_xi == '0) begin
                    e_we = 1'b1; e_wa = r_idx[AW-1:0] - 1'b1; e_wd = e_rd;
                    n_xi = r_xi + 1'b1;
                end else begin
                    x_we = 1'b1; x_wa = xaddr(r_idx[AW-1:0] - 1'b1, r_xi - 1'b1);
                    x_wd = x_rd;
                    if (r_xi == EW'(EXT_DEPTH)) begin
                        n_idx = r_idx + 1'b1; n_state = S_MVRD;
                    end else n_xi = r_xi + 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1; n_ofld = 31'd0; n_ofv = 1'b0; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_ov <= n_ov;
        end
        r_cmd <= n_cmd; r_key <= n_key; r_field <= n_field; r_pos <= n_pos;
        r_idx <= n_idx; r_xi <= n_xi; r_bit <= n_bit; r_any <= n_any;
        r_mask <= n_mask; r_ecnt <= n_ecnt; r_ost <= n_ost; r_okey <= n_okey;
        r_ofld <= n_ofld; r_ofv <= n_ofv; r_olast <= n_olast;
    end

    `DFTT_ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH), "entry count overflow")
    `DFTT_ASSERT_IMPL(a_fv_field, i_clk, i_rst_n, o_valid && !o_field_valid, o_dirty_field == 31'd0, "marker carries a field")
    `DFTT_ASSERT_IMPL(a_nok_key, i_clk, i_rst_n, o_valid && o_status != dftt_pkg::ST_OK, o_found_key == 32'd0 && o_last, "error result malformed")
    `DFTT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "second request taken")
endmodule
`default_nettype wire
